FILE: design/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

  localparam int unsigned SUB_W  = 9;
  localparam int unsigned CELL_W = 8;
  localparam int unsigned DVD_W  = 42;
  localparam int unsigned DVS_W  = 10;
  localparam int unsigned CORD_W = 34;

  localparam logic [SUB_W-1:0] SUB_RESET = 9'd16;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_RANGE  = 2'd2;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [7:0] lat_cell;
    logic [7:0] lon_cell;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [18:0]        slot;
    logic [17:0]        index_word;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_LAT,
    ST_COR_LAT,
    ST_ROT_LAT,
    ST_DIV_LON,
    ST_COR_LON,
    ST_ROT_LON,
    ST_MUL_X,
    ST_MUL_Z,
    ST_RND_Z,
    ST_DIV_TU,
    ST_DIV_TV,
    ST_EMIT_VTX,
    ST_EMIT_IDX,
    ST_EMIT_ERR
  } state_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tri_offset(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd1;
      3'd4: r = 2'd3;
      3'd5: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [CORD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_prod(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [15:0] r;
    t = (p + (64'sd1 <<< 45)) >>> 46;
    if (t > 64'sd16384) begin
      r = 16'sd16384;
    end else if (t < -64'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_sin(input logic signed [31:0] s);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = ($signed({{2{s[31]}}, s}) + 34'sd32768) >>> 16;
    if (t > 34'sd16384) begin
      r = 16'sd16384;
    end else if (t < -34'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/uv_sphere_mesh_generator_top.sv
`default_nettype none
// UV sphere cell tessellator.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat carries a
// latitude and longitude cell number. A beat is taken when valid is high and
// stall is low; stall stays high while a cell is being worked on.
// Output channel (out_valid_o / out_stall_i / out_data_o): a good cell yields
// ten beats, four corner vertices then six index words, the last flagged.
// A cell number at or above the subdivision count yields one range beat.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
// subdivision count; always ready, write only while the block is idle.
// Per corner the sequencer runs four 42-step restoring divides on the
// shared divider and two CORDIC runs on the shared rotator, plus the
// rotate-back, multiply and emit steps.
// A stalled output beat holds in the output register and the sequencer
// waits at its next emit step. Reset empties the output register, returns
// the sequencer to idle and loads 16 into the subdivision count.
module uv_sphere_mesh_generator_top #(
  parameter int MAX_SUBDIV   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  uvs_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output uvs_pkg::out_item_t        out_data_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire [uvs_pkg::SUB_W-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam int unsigned CW    = uvs_pkg::CORD_W;
  localparam int unsigned DW    = uvs_pkg::DVD_W;
  localparam int unsigned SW    = uvs_pkg::DVS_W;

  uvs_pkg::state_e state_q, state_d;

  logic [uvs_pkg::SUB_W-1:0] sub_q, n_q, n_eff;
  logic [7:0]  lat_q, lon_q;
  logic [16:0] cell_q;
  logic [1:0]  corner_q;
  logic [2:0]  idx_q;
  logic        range_err;

  // shared divider
  logic [DW-1:0] dq_q, div_dvd, dq_nx;
  logic [SW-1:0] rem_q, dvs_q, div_dvs, rem_nx;
  logic [SW:0]   rem_sh;
  logic [5:0]    dcnt_q;
  logic          dbusy_q, div_last, div_state, div_ge;

  // shared CORDIC rotator
  logic signed [CW-1:0] cx_q, cy_q, cz_q, xs, ys, at, nx, ny, nz;
  logic signed [CW-1:0] cos_raw, sin_raw, z_init;
  logic [CNT_W-1:0] ccnt_q;
  logic [1:0]  cquad_q, quad_init;
  logic        cbusy_q, cor_last, cor_state;
  logic [31:0] phase, qsum, ru;
  logic signed [31:0] cos_c, sin_c;

  logic signed [31:0] clat_q, clon_q, slon_q;
  logic signed [63:0] prod_q;
  logic signed [15:0] px_q, py_q, pz_q;
  logic [15:0] tu_q;
  logic [8:0]  row, col;
  logic [9:0]  ktv;

  logic out_valid_q, can_load, load_out, in_acc;
  uvs_pkg::out_item_t out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign can_load    = !out_valid_q || !out_stall_i;

  // subdivision count, folded into its legal range
  always_comb begin
    if (sub_q == '0) begin
      n_eff = 9'd1;
    end else if (32'(sub_q) > MAX_SUBDIV) begin
      n_eff = 9'(MAX_SUBDIV);
    end else begin
      n_eff = sub_q;
    end
  end
  assign range_err = ({1'b0, lat_q} >= n_eff) || ({1'b0, lon_q} >= n_eff);

  assign row = {1'b0, lat_q} + 9'(corner_q[0]);
  assign col = {1'b0, lon_q} + 9'(corner_q[1]);
  assign ktv = corner_q[0] ? (10'(n_q) - 10'(lat_q)) : (10'(n_q) - 10'(lat_q) + 10'd1);

  // divider operands per step
  always_comb begin
    div_dvd   = '0;
    div_dvs   = {1'b0, n_q};
    div_state = 1'b1;
    unique case (state_q)
      uvs_pkg::ST_DIV_LAT: div_dvd = DW'({row, 32'd0});
      uvs_pkg::ST_DIV_LON: div_dvd = DW'({col, 32'd0});
      uvs_pkg::ST_DIV_TU: begin
        div_dvd = (DW'(col) << 15) + DW'(n_q);
        div_dvs = {n_q, 1'b0};
      end
      uvs_pkg::ST_DIV_TV: begin
        div_dvd = (DW'(ktv) << 15) + DW'(n_q);
        div_dvs = {n_q, 1'b0};
      end
      default: div_state = 1'b0;
    endcase
  end

  assign rem_sh   = {rem_q, dq_q[DW-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign rem_nx   = div_ge ? SW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SW-1:0];
  assign dq_nx    = {dq_q[DW-2:0], div_ge};
  assign div_last = dbusy_q && (dcnt_q == 6'(DW - 1));

  // CORDIC: phase comes straight from the finished quotient
  assign cor_state = (state_q == uvs_pkg::ST_COR_LAT) || (state_q == uvs_pkg::ST_COR_LON);
  assign phase = (state_q == uvs_pkg::ST_COR_LAT) ? (32'hC000_0000 + dq_q[32:1]) : dq_q[31:0];
  assign qsum      = phase + 32'h2000_0000;
  assign quad_init = qsum[31:30];
  assign ru        = phase - {quad_init, 30'd0};
  assign z_init    = $signed({{2{ru[31]}}, ru});

  always_comb begin
    xs = cx_q >>> ccnt_q;
    ys = cy_q >>> ccnt_q;
    at = $signed({2'b00, uvs_pkg::atan_turn(5'(ccnt_q))});
    if (!cz_q[CW-1]) begin
      nx = cx_q - ys;
      ny = cy_q + xs;
      nz = cz_q - at;
    end else begin
      nx = cx_q + ys;
      ny = cy_q - xs;
      nz = cz_q + at;
    end
  end
  assign cor_last = cbusy_q && (ccnt_q == CNT_W'(CORDIC_STEPS - 1));

  // rotate the quadrant back
  always_comb begin
    unique case (cquad_q)
      2'd0: begin cos_raw = cx_q;  sin_raw = cy_q;  end
      2'd1: begin cos_raw = -cy_q; sin_raw = cx_q;  end
      2'd2: begin cos_raw = -cx_q; sin_raw = -cy_q; end
      default: begin cos_raw = cy_q; sin_raw = -cx_q; end
    endcase
  end
  assign cos_c = uvs_pkg::clamp_q30(cos_raw);
  assign sin_c = uvs_pkg::clamp_q30(sin_raw);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uvs_pkg::ST_IDLE:     if (in_acc) state_d = uvs_pkg::ST_CHECK;
      uvs_pkg::ST_CHECK:    state_d = range_err ? uvs_pkg::ST_EMIT_ERR : uvs_pkg::ST_DIV_LAT;
      uvs_pkg::ST_DIV_LAT:  if (div_last) state_d = uvs_pkg::ST_COR_LAT;
      uvs_pkg::ST_COR_LAT:  if (cor_last) state_d = uvs_pkg::ST_ROT_LAT;
      uvs_pkg::ST_ROT_LAT:  state_d = uvs_pkg::ST_DIV_LON;
      uvs_pkg::ST_DIV_LON:  if (div_last) state_d = uvs_pkg::ST_COR_LON;
      uvs_pkg::ST_COR_LON:  if (cor_last) state_d = uvs_pkg::ST_ROT_LON;
      uvs_pkg::ST_ROT_LON:  state_d = uvs_pkg::ST_MUL_X;
      uvs_pkg::ST_MUL_X:    state_d = uvs_pkg::ST_MUL_Z;
      uvs_pkg::ST_MUL_Z:    state_d = uvs_pkg::ST_RND_Z;
      uvs_pkg::ST_RND_Z:    state_d = uvs_pkg::ST_DIV_TU;
      uvs_pkg::ST_DIV_TU:   if (div_last) state_d = uvs_pkg::ST_DIV_TV;
      uvs_pkg::ST_DIV_TV:   if (div_last) state_d = uvs_pkg::ST_EMIT_VTX;
      uvs_pkg::ST_EMIT_VTX: begin
        if (can_load) begin
          state_d = (corner_q == 2'd3) ? uvs_pkg::ST_EMIT_IDX : uvs_pkg::ST_DIV_LAT;
        end
      end
      uvs_pkg::ST_EMIT_IDX: if (can_load && idx_q == 3'd5) state_d = uvs_pkg::ST_IDLE;
      uvs_pkg::ST_EMIT_ERR: if (can_load) state_d = uvs_pkg::ST_IDLE;
      default:              state_d = uvs_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != uvs_pkg::ST_IDLE);
    load_out   = can_load && ((state_q == uvs_pkg::ST_EMIT_VTX) ||
                              (state_q == uvs_pkg::ST_EMIT_IDX) ||
                              (state_q == uvs_pkg::ST_EMIT_ERR));
  end

  // output beat for the current emit step
  always_comb begin
    out_d = '0;
    unique case (state_q)
      uvs_pkg::ST_EMIT_VTX: begin
        out_d.kind  = uvs_pkg::KIND_VERTEX;
        out_d.slot  = {cell_q, 2'b00} + 19'(corner_q);
        out_d.pos_x = px_q;
        out_d.pos_y = py_q;
        out_d.pos_z = pz_q;
        out_d.tex_u = tu_q;
        out_d.tex_v = dq_q[15:0];
      end
      uvs_pkg::ST_EMIT_IDX: begin
        out_d.kind       = uvs_pkg::KIND_INDEX;
        out_d.slot       = 19'(20'(cell_q) * 20'd6) + 19'(idx_q);
        out_d.index_word = 18'({cell_q, 2'b00}) + 18'(uvs_pkg::tri_offset(idx_q));
        out_d.last       = (idx_q == 3'd5);
      end
      default: begin
        out_d.kind = uvs_pkg::KIND_RANGE;
        out_d.last = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uvs_pkg::ST_IDLE;
      sub_q       <= uvs_pkg::SUB_RESET;
      out_valid_q <= 1'b0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      cbusy_q     <= 1'b0;
      ccnt_q      <= '0;
      corner_q    <= '0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) sub_q <= cfg_data_i;

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (div_state) begin
        if (!dbusy_q) begin
          dbusy_q <= 1'b1;
          dcnt_q  <= '0;
        end else begin
          dcnt_q <= dcnt_q + 6'd1;
          if (div_last) dbusy_q <= 1'b0;
        end
      end

      if (cor_state) begin
        if (!cbusy_q) begin
          cbusy_q <= 1'b1;
          ccnt_q  <= '0;
        end else begin
          ccnt_q <= ccnt_q + CNT_W'(1);
          if (cor_last) cbusy_q <= 1'b0;
        end
      end

      if (state_q == uvs_pkg::ST_CHECK) begin
        corner_q <= '0;
        idx_q    <= '0;
      end
      if (load_out && state_q == uvs_pkg::ST_EMIT_VTX) corner_q <= corner_q + 2'd1;
      if (load_out && state_q == uvs_pkg::ST_EMIT_IDX) idx_q <= idx_q + 3'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lat_q <= in_data_i.lat_cell;
      lon_q <= in_data_i.lon_cell;
    end
    if (state_q == uvs_pkg::ST_CHECK) begin
      n_q    <= n_eff;
      cell_q <= 17'(lat_q) * 17'(n_eff) + 17'(lon_q);
    end

    if (div_state) begin
      if (!dbusy_q) begin
        dq_q  <= div_dvd;
        dvs_q <= div_dvs;
        rem_q <= '0;
      end else begin
        dq_q  <= dq_nx;
        rem_q <= rem_nx;
      end
    end
    // hold tex_u as the tex_v divide loads
    if (state_q == uvs_pkg::ST_DIV_TV && !dbusy_q) tu_q <= dq_q[15:0];

    if (cor_state) begin
      if (!cbusy_q) begin
        cx_q    <= uvs_pkg::CORDIC_GAIN;
        cy_q    <= '0;
        cz_q    <= z_init;
        cquad_q <= quad_init;
      end else begin
        cx_q <= nx;
        cy_q <= ny;
        cz_q <= nz;
      end
    end

    if (state_q == uvs_pkg::ST_ROT_LAT) begin
      clat_q <= cos_c;
      py_q   <= uvs_pkg::round_sin(sin_c);
    end
    if (state_q == uvs_pkg::ST_ROT_LON) begin
      clon_q <= cos_c;
      slon_q <= sin_c;
    end
    if (state_q == uvs_pkg::ST_MUL_X) prod_q <= clat_q * clon_q;
    if (state_q == uvs_pkg::ST_MUL_Z) begin
      px_q   <= uvs_pkg::round_prod(prod_q);
      prod_q <= clat_q * slon_q;
    end
    if (state_q == uvs_pkg::ST_RND_Z) pz_q <= uvs_pkg::round_prod(prod_q);

    if (load_out) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == uvs_pkg::ST_CHECK))
    else $error("accepted cell did not start the range check");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dbusy_q && cbusy_q))
    else $error("divider and rotator busy together");

  a_range_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == uvs_pkg::KIND_RANGE) |-> out_data_o.last)
    else $error("range beat without last");
`endif

endmodule

`default_nettype wire
